// ===== src/jatrc_pkg.sv =====
// Shared types and constants for the joystick axis to RC channel block.
`default_nettype none

package jatrc_pkg;

   localparam int DATA_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int PCT_W        = 8;
   localparam int MODE_W       = 2;

   // pipeline layout: front end, divider steps, curve back end
   localparam int FRONT_STAGES = 3;
   localparam int DIV_STEPS    = 16;
   localparam int BACK_STAGES  = 9;
   localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic [DATA_W-1:0]        norm_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAL_MIN,
      REG_CAL_MAX,
      REG_REVERSE,
      REG_EXPO_PCT,
      REG_CHANNEL_MODE,
      REG_OUT_MIN,
      REG_OUT_MAX,
      REG_OUT_TRIM
   } csr_index_type;

   localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_THROTTLE = 2'd2;
   // spare code, behaves as normal
   localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

   // register reset values
   localparam sample_type RST_CAL_MIN  = 16'sh8000;
   localparam sample_type RST_CAL_MAX  = 16'sh7FFF;
   localparam sample_type RST_OUT_MIN  = 16'sd1000;
   localparam sample_type RST_OUT_MAX  = 16'sd2000;
   localparam sample_type RST_OUT_TRIM = 16'sd1500;

   localparam logic signed [16:0] MIN_CAL_SPAN = 17'sd4096;
   localparam norm_type           NORM_MAX     = 16'hFFFF;

   // centering: trunc((n*1000 - 32767500) / 65535)
   localparam logic [26:0]        CTR_SCALE  = 27'd1000;
   localparam logic signed [26:0] CTR_OFFSET = 27'sd32767500;
   localparam logic [16:0]        CTR_DIVISOR = 17'd65535;

   // output range choices
   localparam logic signed [16:0] DEF_MIN     = 17'sd1000;
   localparam logic signed [16:0] DEF_MAX     = 17'sd2000;
   localparam logic signed [16:0] DEF_TRIM    = 17'sd1500;
   localparam logic signed [16:0] MANUAL_MIN  = -17'sd1000;
   localparam logic signed [16:0] MANUAL_MAX  = 17'sd1000;
   localparam logic signed [16:0] MANUAL_TRIM = 17'sd0;

   // curve, scaled by 50000
   localparam logic signed [PCT_W-1:0] PCT_LIMIT    = 8'sd100;
   localparam logic signed [32:0]      CURVE_SCALE  = 33'sd50000;
   localparam logic signed [10:0]      HALF_TRAVEL  = 11'sd500;
   localparam logic signed [10:0]      FOLD_KNEE    = 11'sd250;
   localparam logic [15:0]             SWEEP_SCALE  = 16'd100;
   localparam logic signed [24:0]      FOLD_SCALE   = 25'sd500;

   // x / 50000 = (x >> 4) / 3125, done as multiply by ceil(2^39 / 3125)
   localparam int          QUOT_LOW_BITS = 4;
   localparam logic [27:0] RECIP_M       = 28'd175921861;
   localparam int          RECIP_SHIFT   = 39;

   typedef struct packed {
      logic [DATA_W-1:0] span;
      norm_type          offset;
      logic              narrow;
      logic              below;
      logic              above;
   } front_type;

   typedef struct packed {
      front_type         front;
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] low;
      logic [DATA_W-1:0] quo;
   } div_type;

   typedef struct packed {
      norm_type   norm;
      sample_type chan;
      logic       dflt;
   } res_type;

endpackage

`default_nettype wire

// ===== src/jatrc_chan_if.sv =====
// Request and response channel interfaces for the joystick axis block.
`default_nettype none

interface jatrc_req_if import jatrc_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink   (input valid, input raw_sample, output ready);
endinterface

interface jatrc_rsp_if import jatrc_pkg::*; ();
   logic       valid;
   logic       ready;
   norm_type   normalized_value;
   sample_type channel_value;
   logic       range_used_default;

   modport source (output valid, output normalized_value, output channel_value,
                   output range_used_default, input ready);
   modport sink   (input valid, input normalized_value, input channel_value,
                   input range_used_default, output ready);
endinterface

`default_nettype wire

// ===== src/joystick_axis_to_rc_channel.sv =====
// Joystick axis to RC channel: calibration, centering, expo curve and clamp.
//
// req_chan carries one signed raw axis sample per request; rsp_chan returns
// the normalized position, the clamped channel value and a flag telling that
// the programmed output range was invalid and defaults were used.
// The csr_ port writes the eight setup registers, one per cycle; the user must
// write them only while no request is in flight, as the block does not enforce it.
//
// Throughput: one request per cycle while the receiver does not stall rsp_chan.
// The pipeline depth is set by the 16-step calibration divider (one quotient
// bit per stage) plus the curve multiplies and the divide by 50000.
//
// Reset empties the pipeline and loads the setup registers with their
// defaults. When the receiver stalls, the result stays on rsp_chan, the
// request leaving the pipeline is parked in a one-entry skid register, and
// req_chan.ready drops until the held result is taken.
`default_nettype none

module joystick_axis_to_rc_channel import jatrc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   jatrc_req_if.sink            req_chan,
   jatrc_rsp_if.source          rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data
);

   // setup registers
   sample_type              cal_min_ff, cal_max_ff;
   logic                    reverse_ff;
   logic signed [PCT_W-1:0] expo_pct_ff;
   logic [MODE_W-1:0]       mode_ff;
   sample_type              out_min_ff, out_max_ff, out_trim_ff;

   // derived range and curve settings
   logic                    manual, throttle, range_bad;
   logic signed [16:0]      lo0, hi0, trim0, lo_v, hi_v, trim_sel, trim_v, mid_sum;
   logic signed [PCT_W-1:0] pct;

   // flow control
   logic                  en;
   logic [NUM_STAGES-1:0] v_ff;
   logic                  skid_v_ff, out_v_ff;
   res_type               skid_ff, out_ff;

   // front end
   sample_type         raw_ff;
   logic signed [16:0] span_full, diff_full;
   front_type          front1_in, front1_ff, front2_ff;
   logic [DATA_W-1:0]  diff1_in, diff1_ff;
   logic [31:0]        num2_in, num2_ff;

   // divider
   div_type div_start;
   div_type div_in [DIV_STEPS];
   div_type div_ff [DIV_STEPS];

   // back end
   norm_type           norm_in;
   norm_type           norm_ff [BACK_STAGES-1];
   logic signed [26:0] x1_in, x1_ff;
   logic               neg2_in, neg2_ff;
   logic [24:0]        mag2_in, mag2_ff;
   logic [8:0]         qe3, q3;
   logic [16:0]        r3;
   logic signed [9:0]  c3_in, c3_ff;
   logic signed [10:0] cx, sc, fold;
   logic               cpos;
   logic signed [16:0] bsel, dlt_full;
   logic signed [32:0] base_full;
   logic signed [18:0] fold_prod;
   logic signed [31:0] base4_in, base4_ff, base5_ff;
   logic [15:0]        sc100_in, sc100_ff;
   logic [15:0]        dlt4_in, dlt4_ff;
   logic signed [15:0] fp4_in, fp4_ff;
   logic [31:0]        prod5_in, prod5_ff;
   logic signed [24:0] fp500_in, fp500_ff;
   logic signed [33:0] acc_full;
   logic signed [31:0] acc6_in, acc6_ff;
   logic               neg7_in, neg7_ff, neg8_ff;
   logic [30:0]        mag7_in, mag7_ff;
   logic [54:0]        quot8_in, quot8_ff;
   logic [15:0]        q9;
   logic signed [16:0] v9, clamp9;
   res_type            res9_in, res9_ff;

   function automatic div_type div_step(input div_type d);
      logic [16:0] trial;
      logic        ge;
      div_type     r;
      trial = {d.rem, d.low[DATA_W-1]};
      ge    = trial >= {1'b0, d.front.span};
      r     = d;
      r.rem = ge ? 16'(trial - {1'b0, d.front.span}) : trial[DATA_W-1:0];
      r.low = {d.low[DATA_W-2:0], 1'b0};
      r.quo = {d.quo[DATA_W-2:0], ge};
      return r;
   endfunction

   // ---------------------------------------------------------------- setup
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_min_ff  <= RST_CAL_MIN;
         cal_max_ff  <= RST_CAL_MAX;
         reverse_ff  <= 1'b0;
         expo_pct_ff <= '0;
         mode_ff     <= '0;
         out_min_ff  <= RST_OUT_MIN;
         out_max_ff  <= RST_OUT_MAX;
         out_trim_ff <= RST_OUT_TRIM;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            REG_CAL_MIN:      cal_min_ff  <= csr_write_data;
            REG_CAL_MAX:      cal_max_ff  <= csr_write_data;
            REG_REVERSE:      reverse_ff  <= csr_write_data[0];
            REG_EXPO_PCT:     expo_pct_ff <= csr_write_data[PCT_W-1:0];
            REG_CHANNEL_MODE: mode_ff     <= csr_write_data[MODE_W-1:0];
            REG_OUT_MIN:      out_min_ff  <= csr_write_data;
            REG_OUT_MAX:      out_max_ff  <= csr_write_data;
            REG_OUT_TRIM:     out_trim_ff <= csr_write_data;
            default:          ;
         endcase
      end
   end

   // user must change setup only while idle (unenforced); these settle long before use
   always_comb begin
      manual    = mode_ff == MODE_MANUAL;
      throttle  = mode_ff == MODE_THROTTLE;
      lo0       = manual ? MANUAL_MIN  : $signed({out_min_ff[DATA_W-1], out_min_ff});
      hi0       = manual ? MANUAL_MAX  : $signed({out_max_ff[DATA_W-1], out_max_ff});
      trim0     = manual ? MANUAL_TRIM : $signed({out_trim_ff[DATA_W-1], out_trim_ff});
      range_bad = (lo0 >= hi0) || (trim0 < lo0) || (trim0 > hi0);
      lo_v      = range_bad ? DEF_MIN  : lo0;
      hi_v      = range_bad ? DEF_MAX  : hi0;
      trim_sel  = range_bad ? DEF_TRIM : trim0;
      mid_sum   = lo_v + hi_v;
      // halve toward zero
      trim_v    = throttle ? ((mid_sum + $signed({16'd0, mid_sum[16]})) >>> 1) : trim_sel;
      if (expo_pct_ff > PCT_LIMIT) begin
         pct = PCT_LIMIT;
      end else if (expo_pct_ff < -PCT_LIMIT) begin
         pct = -PCT_LIMIT;
      end else begin
         pct = expo_pct_ff;
      end
   end

   // ---------------------------------------------------------------- flow
   assign en             = !skid_v_ff;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         skid_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (en) begin
            v_ff <= {v_ff[NUM_STAGES-2:0], req_chan.valid};
         end
         if (skid_v_ff) begin
            if (rsp_chan.ready) begin
               skid_v_ff <= 1'b0;
            end
         end else if (!out_v_ff || rsp_chan.ready) begin
            out_v_ff <= v_ff[NUM_STAGES-1];
         end else begin
            skid_v_ff <= v_ff[NUM_STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (rsp_chan.ready) begin
            out_ff <= skid_ff;
         end
      end else if (!out_v_ff || rsp_chan.ready) begin
         out_ff <= res9_ff;
      end else begin
         skid_ff <= res9_ff;
      end
   end

   assign rsp_chan.valid              = out_v_ff;
   assign rsp_chan.normalized_value   = out_ff.norm;
   assign rsp_chan.channel_value      = out_ff.chan;
   assign rsp_chan.range_used_default = out_ff.dflt;

   // ---------------------------------------------------------------- front end
   always_comb begin
      span_full        = $signed({cal_max_ff[DATA_W-1], cal_max_ff})
                       - $signed({cal_min_ff[DATA_W-1], cal_min_ff});
      diff_full        = $signed({raw_ff[DATA_W-1], raw_ff})
                       - $signed({cal_min_ff[DATA_W-1], cal_min_ff});
      front1_in.span   = span_full[DATA_W-1:0];
      front1_in.offset = {~raw_ff[DATA_W-1], raw_ff[DATA_W-2:0]};
      front1_in.narrow = span_full < MIN_CAL_SPAN;
      front1_in.below  = raw_ff <= cal_min_ff;
      front1_in.above  = raw_ff >= cal_max_ff;
      diff1_in         = diff_full[DATA_W-1:0];
      // diff*65535 + span/2
      num2_in          = {diff1_ff, 16'd0} - {16'd0, diff1_ff}
                       + {17'd0, front1_ff.span[DATA_W-1:1]};
   end

   // quotient fits 16 bits, so the upper half is already below the span
   always_comb begin
      div_start.front = front2_ff;
      div_start.rem   = num2_ff[31:16];
      div_start.low   = num2_ff[15:0];
      div_start.quo   = '0;
      div_in[0]       = div_step(div_start);
      for (int k = 1; k < DIV_STEPS; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   // ---------------------------------------------------------------- back end
   always_comb begin
      // normalize and center
      if (div_ff[DIV_STEPS-1].front.narrow) begin
         norm_in = div_ff[DIV_STEPS-1].front.offset;
      end else if (div_ff[DIV_STEPS-1].front.below) begin
         norm_in = '0;
      end else if (div_ff[DIV_STEPS-1].front.above) begin
         norm_in = NORM_MAX;
      end else begin
         norm_in = div_ff[DIV_STEPS-1].quo;
      end
      x1_in   = $signed({11'd0, norm_in} * CTR_SCALE) - CTR_OFFSET;
      neg2_in = x1_ff[26];
      mag2_in = neg2_in ? 25'(-x1_ff) : x1_ff[24:0];

      // divide by 65535: estimate by the high half, one correction
      qe3   = mag2_ff[24:16];
      r3    = {1'b0, mag2_ff[15:0]} + {8'd0, qe3};
      q3    = qe3 + {8'd0, r3 >= CTR_DIVISOR};
      c3_in = (neg2_ff ^ reverse_ff) ? -$signed({1'b0, q3}) : $signed({1'b0, q3});

      // pick the curve segment and the fold term
      cx        = $signed({c3_ff[9], c3_ff});
      cpos      = !c3_ff[9];
      bsel      = cpos ? trim_v : lo_v;
      base_full = $signed({{16{bsel[16]}}, bsel}) * CURVE_SCALE;
      base4_in  = base_full[31:0];
      sc        = cpos ? cx : cx + HALF_TRAVEL;
      sc100_in  = {7'd0, sc[8:0]} * SWEEP_SCALE;
      dlt_full  = cpos ? hi_v - trim_v : trim_v - lo_v;
      dlt4_in   = dlt_full[15:0];
      if (cx > FOLD_KNEE) begin
         fold = HALF_TRAVEL - cx;
      end else if (cx < -FOLD_KNEE) begin
         fold = -HALF_TRAVEL - cx;
      end else begin
         fold = cx;
      end
      fold_prod = $signed({{8{fold[10]}}, fold}) * $signed({{11{pct[PCT_W-1]}}, pct});
      fp4_in    = fold_prod[15:0];

      prod5_in  = {16'd0, sc100_ff} * {16'd0, dlt4_ff};
      fp500_in  = $signed({{9{fp4_ff[15]}}, fp4_ff}) * FOLD_SCALE;

      acc_full  = $signed({{2{base5_ff[31]}}, base5_ff}) + $signed({2'b0, prod5_ff})
                - $signed({{9{fp500_ff[24]}}, fp500_ff});
      acc6_in   = acc_full[31:0];

      // divide by 50000, truncating toward zero
      neg7_in   = acc6_ff[31];
      mag7_in   = neg7_in ? 31'(-acc6_ff) : acc6_ff[30:0];
      quot8_in  = 55'(mag7_ff[30:QUOT_LOW_BITS]) * 55'(RECIP_M);
      q9        = quot8_ff[RECIP_SHIFT +: 16];
      v9        = neg8_ff ? -$signed({1'b0, q9}) : $signed({1'b0, q9});
      if (v9 < lo_v) begin
         clamp9 = lo_v;
      end else if (v9 > hi_v) begin
         clamp9 = hi_v;
      end else begin
         clamp9 = v9;
      end
      res9_in.norm = norm_ff[BACK_STAGES-2];
      res9_in.chan = clamp9[15:0];
      res9_in.dflt = range_bad;
   end

   // ---------------------------------------------------------------- datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         raw_ff    <= req_chan.raw_sample;
         front1_ff <= front1_in;
         diff1_ff  <= diff1_in;
         front2_ff <= front1_ff;
         num2_ff   <= num2_in;
         for (int k = 0; k < DIV_STEPS; k++) begin
            div_ff[k] <= div_in[k];
         end
         norm_ff[0] <= norm_in;
         for (int k = 1; k < BACK_STAGES-1; k++) begin
            norm_ff[k] <= norm_ff[k-1];
         end
         x1_ff    <= x1_in;
         neg2_ff  <= neg2_in;
         mag2_ff  <= mag2_in;
         c3_ff    <= c3_in;
         base4_ff <= base4_in;
         sc100_ff <= sc100_in;
         dlt4_ff  <= dlt4_in;
         fp4_ff   <= fp4_in;
         base5_ff <= base4_ff;
         prod5_ff <= prod5_in;
         fp500_ff <= fp500_in;
         acc6_ff  <= acc6_in;
         neg7_ff  <= neg7_in;
         mag7_ff  <= mag7_in;
         neg8_ff  <= neg7_ff;
         quot8_ff <= quot8_in;
         res9_ff  <= res9_in;
      end
   end

endmodule

`default_nettype wire
